@@ design/sps_pkg.sv @@
// Shared types and constants for the support point search block.
// Used by sps_dot, sps_track and support_point_search; no dependencies.
package sps_pkg;

  // Field widths fixed by the stream formats
  localparam int FIELD_W     = 24;
  localparam int INDEX_W     = 16;
  localparam int S_TDATA_W   = 3 * FIELD_W;            // 72 bits, 9 bytes
  localparam int M_TDATA_W   = INDEX_W + 3 * FIELD_W;  // 88 bits, 11 bytes
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_Z = 2'd2;

  // One vertex as carried down the pipeline
  typedef struct packed {
    logic [FIELD_W-1:0] vx;
    logic [FIELD_W-1:0] vy;
    logic [FIELD_W-1:0] vz;
    logic               last;
  } sps_vtx_t;

endpackage

@@ design/sps_dot.sv @@
// Input register and product stage: captures each vertex and forms the three
// direction products. Depends on sps_pkg.
module sps_dot #(
  parameter int COORD_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               hold,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sps_pkg::S_TDATA_W-1:0]      s_tdata,   // vx [23:0], vy [47:24], vz [71:48]
  input  logic                               s_tlast,
  input  logic [sps_pkg::FIELD_W-1:0]        dir_x,
  input  logic [sps_pkg::FIELD_W-1:0]        dir_y,
  input  logic [sps_pkg::FIELD_W-1:0]        dir_z,
  output logic                               prod_valid,
  output sps_pkg::sps_vtx_t                  prod_vtx,
  output logic signed [2*COORD_BITS-1:0]     prod_x,
  output logic signed [2*COORD_BITS-1:0]     prod_y,
  output logic signed [2*COORD_BITS-1:0]     prod_z
);

  localparam int FW = sps_pkg::FIELD_W;

  // Take the low COORD_BITS bits of a field as a two's complement value
  function automatic logic signed [COORD_BITS-1:0] coord(input logic [FW-1:0] raw);
    logic [31:0] wide;
    wide = 32'(raw);
    return wide[COORD_BITS-1:0];
  endfunction

  logic              in_valid;
  sps_pkg::sps_vtx_t in_vtx;
  logic signed [COORD_BITS-1:0] cx, cy, cz, dx, dy, dz;

  assign s_tready = !hold;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!hold) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      in_vtx.vx   <= s_tdata[FW-1:0];
      in_vtx.vy   <= s_tdata[2*FW-1:FW];
      in_vtx.vz   <= s_tdata[3*FW-1:2*FW];
      in_vtx.last <= s_tlast;
    end
  end

  // Operands of the three multiplies
  always_comb begin
    cx = coord(in_vtx.vx);
    cy = coord(in_vtx.vy);
    cz = coord(in_vtx.vz);
    dx = coord(dir_x);
    dy = coord(dir_y);
    dz = coord(dir_z);
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (!hold) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      prod_vtx <= in_vtx;
      prod_x   <= cx * dx;
      prod_y   <= cy * dy;
      prod_z   <= cz * dz;
    end
  end

endmodule

@@ design/sps_track.sv @@
// Running best tracker and result register: sums the products, keeps the
// largest dot with its index and point, and emits a result per mesh. Depends on sps_pkg.
module sps_track #(
  parameter int COORD_BITS   = 24,
  parameter int MAX_VERTICES = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               prod_valid,
  input  sps_pkg::sps_vtx_t                  prod_vtx,
  input  logic signed [2*COORD_BITS-1:0]     prod_x,
  input  logic signed [2*COORD_BITS-1:0]     prod_y,
  input  logic signed [2*COORD_BITS-1:0]     prod_z,
  output logic                               hold,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // best_vertex_index [15:0], best_px [39:16], best_py [63:40], best_pz [87:64]
  output logic [sps_pkg::M_TDATA_W-1:0]      m_tdata
);

  localparam int FW    = sps_pkg::FIELD_W;
  localparam int IW    = sps_pkg::INDEX_W;
  localparam int DOT_W = 2 * COORD_BITS + 2;

  logic signed [DOT_W-1:0] best_dot, dot;
  logic [IW-1:0]           best_index, count, count_next;
  logic [FW-1:0]           best_x, best_y, best_z;
  logic                    have_best;
  logic [IW:0]             count_inc;
  logic                    fire, take;
  logic [IW-1:0]           res_index;
  logic [FW-1:0]           res_x, res_y, res_z;

  // Dot product and compare against the running best
  always_comb begin
    dot = DOT_W'(prod_x) + DOT_W'(prod_y) + DOT_W'(prod_z);
    take = !have_best || (dot > best_dot);
    count_inc = {1'b0, count} + 1'b1;
    if (32'(count_inc) >= 32'(MAX_VERTICES)) begin
      count_next = '0;
    end else begin
      count_next = count_inc[IW-1:0];
    end
    res_index = take ? count       : best_index;
    res_x     = take ? prod_vtx.vx : best_x;
    res_y     = take ? prod_vtx.vy : best_y;
    res_z     = take ? prod_vtx.vz : best_z;
  end

  // Stall only when a mesh end meets an untaken result
  assign hold = prod_valid && prod_vtx.last && m_tvalid && !m_tready;
  assign fire = prod_valid && !hold;

  // Running best state; clear at mesh end
  always_ff @(posedge clk) begin
    if (rst) begin
      best_dot   <= '0;
      best_index <= '0;
      best_x     <= '0;
      best_y     <= '0;
      best_z     <= '0;
      count      <= '0;
      have_best  <= 1'b0;
    end else if (fire) begin
      if (prod_vtx.last) begin
        best_dot   <= '0;
        best_index <= '0;
        best_x     <= '0;
        best_y     <= '0;
        best_z     <= '0;
        count      <= '0;
        have_best  <= 1'b0;
      end else begin
        if (take) begin
          best_dot   <= dot;
          best_index <= count;
          best_x     <= prod_vtx.vx;
          best_y     <= prod_vtx.vy;
          best_z     <= prod_vtx.vz;
        end
        count     <= count_next;
        have_best <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && prod_vtx.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && prod_vtx.last) begin
      m_tdata <= {res_z, res_y, res_x, res_index};
    end
  end

  // A result appears only after a mesh end passed the tracker
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fire && prod_vtx.last))
    else $error("result raised without a mesh end");

  // Mesh end leaves the tracker cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && prod_vtx.last |=> !have_best && (count == '0) && (best_dot == '0))
    else $error("tracker not cleared after mesh end");

  // Stall only while the result register is full and blocked
  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    hold |-> m_tvalid && !m_tready)
    else $error("stall without a blocked result");

  // With no vertex seen the index counter is at its start
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> (count == '0))
    else $error("counter moved with no vertex seen");

endmodule

@@ design/support_point_search.sv @@
// Top level of the support point search: direction registers and the
// two pipeline parts. Depends on sps_pkg, sps_dot and sps_track.
//
// Takes one vertex per clock cycle while not stalled, and dots it with the
// direction held in dir_x/dir_y/dir_z (exact products, exact sum); the result
// for a mesh passes the input and product registers into the result register
// after its last vertex is transferred. The rate is set by the compare-and-update
// of the running best, combinational logic ahead of the best registers. The input
// side stalls only when a mesh ends while the previous mesh's result is still
// waiting on the output. Ties keep the earliest vertex; indices wrap after
// MAX_VERTICES vertices. Write the direction only while no vertex is in flight.
module support_point_search #(
  parameter int COORD_BITS   = 24,
  parameter int MAX_VERTICES = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // vx [23:0], vy [47:24], vz [71:48]
  input  logic [sps_pkg::S_TDATA_W-1:0]         s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic                                  s_tlast,
  // best_vertex_index [15:0], best_px [39:16], best_py [63:40], best_pz [87:64]
  output logic [sps_pkg::M_TDATA_W-1:0]         m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_we,
  input  logic [sps_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sps_pkg::FIELD_W-1:0]           cfg_wdata
);

  logic [sps_pkg::FIELD_W-1:0]       dir_x, dir_y, dir_z;
  logic                              hold;
  logic                              prod_valid;
  sps_pkg::sps_vtx_t                 prod_vtx;
  logic signed [2*COORD_BITS-1:0]    prod_x, prod_y, prod_z;

  // Direction registers; drop writes beyond dir_z
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sps_pkg::CFG_DIR_X: dir_x <= cfg_wdata;
        sps_pkg::CFG_DIR_Y: dir_y <= cfg_wdata;
        sps_pkg::CFG_DIR_Z: dir_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sps_dot #(
    .COORD_BITS (COORD_BITS)
  ) u_dot (
    .clk        (clk),
    .rst        (rst),
    .hold       (hold),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .prod_valid (prod_valid),
    .prod_vtx   (prod_vtx),
    .prod_x     (prod_x),
    .prod_y     (prod_y),
    .prod_z     (prod_z)
  );

  sps_track #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_vtx   (prod_vtx),
    .prod_x     (prod_x),
    .prod_y     (prod_y),
    .prod_z     (prod_z),
    .hold       (hold),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
